/* sv/tp2p_pkg.sv */
// ----------------------------------------------------------------------------
// tp2p_pkg: shared constants for the trimmed peak-to-peak detector
// Holds the default sizing, the fixed port widths and the gain reset value.
// ----------------------------------------------------------------------------
`default_nettype none

package tp2p_pkg;

  // Default number of entries in each trimmed set.
  localparam int unsigned TopCountDef = 5;
  // Default number of sample bits actually used.
  localparam int unsigned SampleWidthDef = 16;

  // Fixed port widths.
  localparam int unsigned SampleInW = 16;
  localparam int unsigned GainW     = 16;
  localparam int unsigned VppW      = 32;
  localparam int unsigned SpanOutW  = 19;

  // Gain in 0.16 fixed point, floor(1.03 * 0.122 * 65536).
  localparam logic [GainW-1:0] GainReset = 16'd8235;

endpackage

`default_nettype wire

/* sv/tp2p_rank.sv */
// ----------------------------------------------------------------------------
// tp2p_rank: sorted set of the K most extreme samples of a record
// Keeps TOP_COUNT entries in order and inserts one sample per cycle while ins_i
// is high, by a parallel compare and shift. Exposes the set as it stands after
// inserting the current sample, so the caller can capture it on the closing item.
// ----------------------------------------------------------------------------
`default_nettype none

module tp2p_rank #(
  parameter int unsigned TOP_COUNT    = tp2p_pkg::TopCountDef,
  parameter int unsigned SAMPLE_WIDTH = tp2p_pkg::SampleWidthDef,
  parameter bit          DESCEND      = 1'b1
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    ins_i,
  input  wire logic                                    clr_i,
  input  wire logic [SAMPLE_WIDTH-1:0]                 sample_i,
  output logic      [TOP_COUNT-1:0][SAMPLE_WIDTH-1:0]  set_o
);

  localparam logic [SAMPLE_WIDTH-1:0] Fill = DESCEND ? '0 : '1;

  logic [TOP_COUNT-1:0][SAMPLE_WIDTH-1:0] set_q;
  logic [TOP_COUNT-1:0][SAMPLE_WIDTH-1:0] set_d;
  logic [TOP_COUNT-1:0]                   better;

  // The set is sorted, so the "better" flags form a thermometer code: the
  // first set flag is the slot the sample lands in, later slots shift by one.
  always_comb begin
    for (int i = 0; i < TOP_COUNT; i++) begin
      better[i] = DESCEND ? (sample_i > set_q[i]) : (sample_i < set_q[i]);
    end
    set_o[0] = better[0] ? sample_i : set_q[0];
    for (int i = 1; i < TOP_COUNT; i++) begin
      if (!better[i]) begin
        set_o[i] = set_q[i];
      end else if (!better[i-1]) begin
        set_o[i] = sample_i;
      end else begin
        set_o[i] = set_q[i-1];
      end
    end
  end

  always_comb begin
    set_d = set_q;
    if (ins_i) begin
      if (clr_i) begin
        set_d = {TOP_COUNT{Fill}};
      end else begin
        set_d = set_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_q <= {TOP_COUNT{Fill}};
    end else begin
      set_q <= set_d;
    end
  end

endmodule

`default_nettype wire

/* sv/trimmed_peak_to_peak.sv */
// Pipeline: the item carrying the last flag is snapshot at the edge that
//   accepts it, then passes the sum, span, quotient and gain stages to the output.
// Throughput: one sample per cycle; the whole pipeline stalls only while a
//   finished result waits at the output and out_ready_i is low.
// Reset: both trimmed sets, the sample counter and all valid bits clear
//   asynchronously on rst_ni low; the gain register returns to its default.
// ----------------------------------------------------------------------------
// trimmed_peak_to_peak: trimmed peak-to-peak detector for one sample record
// Tracks the K largest and K smallest samples of a record and, on the last
// sample, reports their sum difference and that span scaled by gain / K.
// ----------------------------------------------------------------------------
`default_nettype none

module trimmed_peak_to_peak #(
  parameter int unsigned TOP_COUNT    = tp2p_pkg::TopCountDef,
  parameter int unsigned SAMPLE_WIDTH = tp2p_pkg::SampleWidthDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Gain register write port.
  input  wire logic                             cfg_we_i,
  input  wire logic [tp2p_pkg::GainW-1:0]       cfg_wdata_i,
  // Sample input channel.
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [tp2p_pkg::SampleInW-1:0]   sample_i,
  input  wire logic                             last_i,
  // Result output channel.
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic      [tp2p_pkg::VppW-1:0]        vpp_o,
  output logic      [tp2p_pkg::SpanOutW-1:0]    span_o,
  output logic                                  too_few_o
);

  localparam int unsigned GainW = tp2p_pkg::GainW;
  localparam int unsigned VppW  = tp2p_pkg::VppW;
  localparam int unsigned CntW  = $clog2(TOP_COUNT + 1);
  // Width of a sum of K samples; the span never exceeds that sum.
  localparam int unsigned SumW  =
    $clog2(TOP_COUNT * ((1 << SAMPLE_WIDTH) - 1) + 1);
  localparam int unsigned SpanW = SumW;
  // Remainder of a division by K.
  localparam int unsigned RemW  = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
  localparam int unsigned RgW   = RemW + GainW;

  // Division by K through a multiply by ceil(2^s / K). With s = W + clog2(K)
  // the quotient is exact for every W-bit dividend.
  localparam int unsigned QShift = SpanW + $clog2(TOP_COUNT);
  localparam longint unsigned QRecipL =
    ((64'd1 << QShift) + TOP_COUNT - 1) / TOP_COUNT;
  localparam int unsigned QProdW = SpanW + QShift + 1;
  localparam logic [QProdW-1:0] QRecip = QProdW'(QRecipL);

  localparam int unsigned FShift = RgW + $clog2(TOP_COUNT);
  localparam longint unsigned FRecipL =
    ((64'd1 << FShift) + TOP_COUNT - 1) / TOP_COUNT;
  localparam int unsigned FProdW = RgW + FShift + 1;
  localparam logic [FProdW-1:0] FRecip = FProdW'(FRecipL);

  localparam int unsigned HiW = (SpanW + GainW > VppW) ? SpanW + GainW : VppW;

  typedef logic [TOP_COUNT-1:0][SAMPLE_WIDTH-1:0] set_t;

  // --------------------------------------------------------------------------
  // Handshake. Every stage moves together; the pipeline freezes only when a
  // result sits at the output and is not being taken.
  // --------------------------------------------------------------------------
  logic adv;
  logic accept;
  logic close;

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;
  assign accept     = in_valid_i && adv;
  assign close      = accept && last_i;

  // --------------------------------------------------------------------------
  // Gain register.
  // --------------------------------------------------------------------------
  logic [GainW-1:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= tp2p_pkg::GainReset;
    end else if (cfg_we_i) begin
      gain_q <= cfg_wdata_i;
    end
  end

  // --------------------------------------------------------------------------
  // Trimmed sets and the saturating sample counter. Bits above SAMPLE_WIDTH
  // of the incoming sample are dropped.
  // --------------------------------------------------------------------------
  logic [SAMPLE_WIDTH-1:0] sample_w;
  set_t                    top_set;
  set_t                    bot_set;
  logic [CntW-1:0]         cnt_q;
  logic [CntW-1:0]         cnt_d;
  logic                    few_now;

  assign sample_w = sample_i[SAMPLE_WIDTH-1:0];

  tp2p_rank #(
    .TOP_COUNT    (TOP_COUNT),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .DESCEND      (1'b1)
  ) u_largest (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ins_i    (accept),
    .clr_i    (last_i),
    .sample_i (sample_w),
    .set_o    (top_set)
  );

  tp2p_rank #(
    .TOP_COUNT    (TOP_COUNT),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .DESCEND      (1'b0)
  ) u_smallest (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ins_i    (accept),
    .clr_i    (last_i),
    .sample_i (sample_w),
    .set_o    (bot_set)
  );

  // After this sample the count is still below K exactly when it was below
  // K - 1 before it.
  assign few_now = cnt_q < CntW'(TOP_COUNT - 1);

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      if (last_i) begin
        cnt_d = '0;
      end else if (cnt_q < CntW'(TOP_COUNT)) begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: snapshot of both sets, including the closing sample.
  // --------------------------------------------------------------------------
  logic v1_q, few1_q;
  set_t top1_q, bot1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= close;
    end
  end

  always_ff @(posedge clk_i) begin
    if (close) begin
      top1_q <= top_set;
      bot1_q <= bot_set;
      few1_q <= few_now;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: sums of the two sets.
  // --------------------------------------------------------------------------
  logic            v2_q, few2_q;
  logic [SumW-1:0] top_sum, bot_sum;
  logic [SumW-1:0] top_sum_q, bot_sum_q;

  always_comb begin
    top_sum = '0;
    bot_sum = '0;
    for (int i = 0; i < TOP_COUNT; i++) begin
      top_sum = top_sum + SumW'(top1_q[i]);
      bot_sum = bot_sum + SumW'(bot1_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      top_sum_q <= top_sum;
      bot_sum_q <= bot_sum;
      few2_q    <= few1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: span. A short record forces zero here, which carries through the
  // scaling to vpp as well.
  // --------------------------------------------------------------------------
  logic             v3_q, few3_q;
  logic [SpanW-1:0] span3_d, span3_q;

  always_comb begin
    if (few2_q || (top_sum_q < bot_sum_q)) begin
      span3_d = '0;
    end else begin
      span3_d = top_sum_q - bot_sum_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      span3_q <= span3_d;
      few3_q  <= few2_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: quotient of span by K.
  // --------------------------------------------------------------------------
  logic              v4_q, few4_q;
  logic [QProdW-1:0] qprod;
  logic [SpanW-1:0]  quo4_q, span4_q;

  assign qprod = QProdW'(span3_q) * QRecip;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      quo4_q  <= qprod[QShift +: SpanW];
      span4_q <= span3_q;
      few4_q  <= few3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: span * gain / K = quo * gain + (rem * gain) / K. The first term
  // is formed here, the remainder term is prepared for the last stage.
  // --------------------------------------------------------------------------
  logic             v5_q, few5_q;
  logic [SpanW-1:0] rem_full;
  logic [RemW-1:0]  rem;
  logic [HiW-1:0]   hi_full;
  logic [VppW-1:0]  hi5_q;
  logic [RgW-1:0]   rg5_q;
  logic [SpanW-1:0] span5_q;

  assign rem_full = span4_q - SpanW'(quo4_q * TOP_COUNT);
  assign rem      = rem_full[RemW-1:0];
  assign hi_full  = HiW'(quo4_q) * HiW'(gain_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (adv) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hi5_q   <= hi_full[VppW-1:0];
      rg5_q   <= RgW'(rem) * RgW'(gain_q);
      span5_q <= span4_q;
      few5_q  <= few4_q;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: remainder term divided by K and the final sum.
  // --------------------------------------------------------------------------
  logic [FProdW-1:0] fprod;
  logic [RgW-1:0]    frac;

  assign fprod = FProdW'(rg5_q) * FRecip;
  assign frac  = fprod[FShift +: RgW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vpp_o     <= hi5_q + VppW'(frac);
      span_o    <= tp2p_pkg::SpanOutW'(span5_q);
      too_few_o <= few5_q;
    end
  end

endmodule

`default_nettype wire

/* tb/trimmed_peak_to_peak_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trimmed_peak_to_peak_tb: self-checking bench for the trimmed peak-to-peak unit
// Streams sample records through the input channel in random bursts and
// predicts each record's span, scaled span and short-record flag from a
// behavioral copy of both trimmed sets. Results are checked in order against
// that prediction while the output side stalls on its own pattern. The gain
// register is rewritten between phases, covering zero, one, full scale and
// the reset value.
// ----------------------------------------------------------------------------

module trimmed_peak_to_peak_tb;

  localparam int unsigned K              = tp2p_pkg::TopCountDef;
  localparam int unsigned SampleInW      = tp2p_pkg::SampleInW;
  localparam int unsigned SampleWidthDef = tp2p_pkg::SampleWidthDef;
  localparam int unsigned GainW          = tp2p_pkg::GainW;
  localparam int unsigned VppW           = tp2p_pkg::VppW;
  localparam int unsigned SpanOutW       = tp2p_pkg::SpanOutW;
  localparam logic [GainW-1:0] GainReset = tp2p_pkg::GainReset;
  localparam logic [SampleInW-1:0] SampleMask =
      {SampleInW{1'b1}} >> (SampleInW - SampleWidthDef);
  // Depth of the result pipeline after the last item of a record is taken.
  localparam int unsigned PipeDepth = 5;
  localparam int unsigned SettleCycles = 4 * PipeDepth;
  localparam int unsigned CycleLimit = 250000;
  localparam int unsigned PhaseCount = 7;

  typedef struct packed {
    logic [SampleInW-1:0] sample;
    logic                 last;
  } sample_item_t;

  typedef struct packed {
    logic [VppW-1:0]     vpp;
    logic [SpanOutW-1:0] span;
    logic                too_few;
  } record_result_t;

  // Clock, reset and the block's inputs, all known from time zero.
  logic                 clk_i;
  logic                 rst_n       = 1'b0;
  logic                 cfg_we      = 1'b0;
  logic [GainW-1:0]     cfg_wdata   = '0;
  logic                 in_valid    = 1'b0;
  logic [SampleInW-1:0] in_sample   = '0;
  logic                 in_last     = 1'b0;
  logic                 out_ready   = 1'b0;

  logic                 in_ready_o;
  logic                 out_valid_o;
  logic [VppW-1:0]      vpp_o;
  logic [SpanOutW-1:0]  span_o;
  logic                 too_few_o;

  trimmed_peak_to_peak dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .sample_i    (in_sample),
    .last_i      (in_last),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .vpp_o       (vpp_o),
    .span_o      (span_o),
    .too_few_o   (too_few_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Samples waiting to be offered, and the results that the records already
  // taken by the block must produce, oldest first.
  sample_item_t   sample_backlog[$];
  record_result_t expected_results[$];

  // Behavioral copy of the block: the K largest samples in descending order,
  // the K smallest in ascending order, a saturating count, and the gain.
  logic [SampleInW-1:0] top_set[K];
  logic [SampleInW-1:0] bottom_set[K];
  int unsigned          record_fill;
  logic [GainW-1:0]     gain_now = GainReset;

  // Bookkeeping for the summary.
  int unsigned samples_taken = 0;
  int unsigned results_seen  = 0;
  int unsigned short_records = 0;
  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;

  // Sender and receiver pacing.
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  int unsigned stall_tick = 0;
  sample_item_t   next_item;
  record_result_t oldest;

  function automatic void clear_record_sets();
    for (int i = 0; i < K; i++) begin
      top_set[i]    = '0;
      bottom_set[i] = SampleMask;
    end
    record_fill = 0;
  endfunction

  // Folds one accepted sample into the sets. On the closing sample it
  // predicts the record's result and starts a fresh record.
  function automatic void absorb_sample(logic [SampleInW-1:0] raw, logic closes);
    logic [SampleInW-1:0] v;
    int                   slot;
    longint unsigned      top_sum;
    longint unsigned      bottom_sum;
    longint unsigned      diff;
    record_result_t       res;

    v = raw & SampleMask;

    // The new sample goes in front of the first entry it beats; the tail
    // entry falls off.
    slot = K;
    for (int i = K - 1; i >= 0; i--) begin
      if (v > top_set[i]) slot = i;
    end
    if (slot < K) begin
      for (int j = K - 1; j > slot; j--) top_set[j] = top_set[j-1];
      top_set[slot] = v;
    end

    slot = K;
    for (int i = K - 1; i >= 0; i--) begin
      if (v < bottom_set[i]) slot = i;
    end
    if (slot < K) begin
      for (int j = K - 1; j > slot; j--) bottom_set[j] = bottom_set[j-1];
      bottom_set[slot] = v;
    end

    if (record_fill < K) record_fill++;
    if (!closes) return;

    res = '0;
    if (record_fill < K) begin
      // A short record would trim to the same samples on both sides.
      res.too_few = 1'b1;
      short_records++;
    end else begin
      top_sum    = 0;
      bottom_sum = 0;
      for (int i = 0; i < K; i++) begin
        top_sum    += top_set[i];
        bottom_sum += bottom_set[i];
      end
      diff     = (top_sum >= bottom_sum) ? top_sum - bottom_sum : 0;
      res.span = diff[SpanOutW-1:0];
      res.vpp  = VppW'((diff * longint'(gain_now)) / K);
    end
    expected_results.push_back(res);
    clear_record_sets();
  endfunction

  // Input driver. The payload holds while valid waits for ready; a new item
  // is only picked once the current one has been taken.
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        absorb_sample(in_sample, in_last);
        samples_taken++;
      end
      if (!in_valid || in_ready_o) begin
        if (gap_left != 0 || sample_backlog.size() == 0) begin
          if (gap_left != 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          next_item = sample_backlog.pop_front();
          in_valid  <= 1'b1;
          in_sample <= next_item.sample;
          in_last   <= next_item.last;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            // Every fourth burst or so is a long run with no gap at all.
            if ($urandom_range(0, 3) == 0) begin
              burst_left = $urandom_range(60, 200);
              gap_left   = 0;
            end else begin
              burst_left = $urandom_range(0, 30);
              gap_left   = $urandom_range(1, 8);
            end
          end
        end
      end
    end
  end

  // Output monitor with its own stall pattern. The pattern switches between
  // always ready, coin-flip, mostly stalled and a periodic long stall.
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] result with none expected: vpp=%0d span=%0d too_few=%0b",
                     $realtime, vpp_o, span_o, too_few_o);
        end else begin
          oldest = expected_results.pop_front();
          if (vpp_o !== oldest.vpp || span_o !== oldest.span ||
              too_few_o !== oldest.too_few) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] result %0d: expected vpp=%0d span=%0d too_few=%0b",
                       $realtime, results_seen, oldest.vpp, oldest.span,
                       oldest.too_few);
              $display("    got vpp=%0d span=%0d too_few=%0b",
                       vpp_o, span_o, too_few_o);
            end
          end
        end
      end

      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 150);
      end else begin
        stall_left--;
      end
      stall_tick++;
      case (stall_mode)
        0: begin
          out_ready <= 1'b1;
        end
        1: begin
          out_ready <= ($urandom_range(0, 1) == 1);
        end
        2: begin
          out_ready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          out_ready <= ((stall_tick % 23) >= 17);
        end
      endcase
    end
  end

  // Watchdog: the slowest correct run needs a small fraction of this.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles with %0d results still expected",
               cycle_count, expected_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic queue_sample(logic [SampleInW-1:0] value, logic closes);
    sample_item_t item;
    item.sample = value;
    item.last   = closes;
    sample_backlog.push_back(item);
  endtask

  // One record of random content. The flavor picks how values are spread: full range,
  // a narrow band that forces many ties, mostly rail values, or one bit flipped from a base.
  task automatic queue_random_record(int unsigned len);
    int unsigned          flavor;
    logic [SampleInW-1:0] base;
    logic [SampleInW-1:0] value;
    flavor = $urandom_range(0, 5);
    base   = SampleInW'($urandom_range(0, 16'hFFFF));
    for (int unsigned n = 0; n < len; n++) begin
      case (flavor)
        0, 1, 2: begin
          value = SampleInW'($urandom_range(0, 16'hFFFF));
        end
        3: begin
          value = base + SampleInW'($urandom_range(0, 3));
        end
        4: begin
          value = ($urandom_range(0, 3) == 0) ? SampleInW'($urandom_range(0, 16'hFFFF)) :
                  (($urandom_range(0, 1) == 1) ? SampleMask : '0);
        end
        default: begin
          value = base ^ (16'h1 << $urandom_range(0, SampleInW - 1));
        end
      endcase
      queue_sample(value, n == len - 1);
    end
  endtask

  // Mostly ordinary records, with short ones and long ones mixed in.
  task automatic queue_random_records(int unsigned budget);
    int unsigned queued;
    int unsigned len;
    int unsigned pick;
    queued = 0;
    while (queued < budget) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) len = $urandom_range(1, K - 1);
      else if (pick == 1) len = $urandom_range(30, 60);
      else len = $urandom_range(K, 3 * K);
      queue_random_record(len);
      queued += len;
    end
  endtask

  // Five rail-to-rail pairs: the largest span the block can report.
  task automatic queue_full_swing_record();
    for (int n = 0; n < 2 * K; n++)
      queue_sample((n % 2 == 0) ? SampleMask : '0, n == 2 * K - 1);
  endtask

  // Waits until every item is in and every result is out, then lets the
  // pipeline settle before anything else happens.
  task automatic wait_until_drained();
    while (sample_backlog.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_gain(logic [GainW-1:0] value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    gain_now  = value;
    @(negedge clk_i);
  endtask

  logic [GainW-1:0] phase_gain[PhaseCount];

  initial begin
    clear_record_sets();
    phase_gain[0] = GainReset;
    phase_gain[1] = 16'hFFFF;
    phase_gain[2] = 16'h0000;
    phase_gain[3] = 16'h0001;
    phase_gain[4] = GainW'($urandom_range(2, 16'hFFFE));
    phase_gain[5] = GainReset;
    phase_gain[6] = GainW'($urandom_range(0, 16'hFFFF));

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;
    @(negedge clk_i);

    // Directed records under the reset gain. A one-sample record and a
    // four-sample record are both too short. A record of exactly K samples
    // with ties trims to the same set on both sides. The full swing record
    // gives the widest span, and the last record mixes ties across both sets.
    queue_sample(SampleMask, 1'b1);
    queue_sample(16'h0000, 1'b0);
    queue_sample(SampleMask, 1'b0);
    queue_sample(16'h5555, 1'b0);
    queue_sample(16'hAAAA, 1'b1);
    queue_sample(16'd7, 1'b0);
    queue_sample(16'd7, 1'b0);
    queue_sample(16'd3, 1'b0);
    queue_sample(SampleMask, 1'b0);
    queue_sample(16'd7, 1'b1);
    queue_full_swing_record();
    queue_sample(16'd3, 1'b0);
    for (int n = 0; n < 4; n++) queue_sample(16'd9, 1'b0);
    queue_sample(16'd3, 1'b1);
    queue_random_records(110);
    wait_until_drained();

    // Later phases each start from a new gain, the extremes among them.
    for (int p = 1; p < PhaseCount; p++) begin
      write_gain(phase_gain[p]);
      queue_full_swing_record();
      queue_random_records(125);
      wait_until_drained();
    end

    $display("Streamed %0d samples in %0d records (%0d too short) over %0d gain settings.",
             samples_taken, results_seen, short_records, PhaseCount);
    $display("Gains covered zero, one, full scale and the reset value; %0d mismatches.",
             mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
